>>> rtl/radar_trace_stacker_top_assert.svh
// ---------------------------------------------------------------------------
// Radar trace stacker assertion macros
// Immediate-implication and next-cycle-implication checks on clk, gated by rst.
// ---------------------------------------------------------------------------
`ifndef RADAR_TRACE_STACKER_TOP_ASSERT_SVH
`define RADAR_TRACE_STACKER_TOP_ASSERT_SVH

// cons must hold in the same cycle as ante
`define RTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("radar trace stacker: check failed");

// cons must hold in the cycle after ante
`define RTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("radar trace stacker: check failed");

`endif

>>> rtl/rts_pkg.sv
// ---------------------------------------------------------------------------
// rts_pkg
// Shared constants, types and the divider step for the radar trace stacker.
// ---------------------------------------------------------------------------
package rts_pkg;

  localparam int MAX_TRACE_LEN = 4096;
  localparam int MAX_STACK     = 4096;

  localparam int IDX_W   = $clog2(MAX_TRACE_LEN);
  localparam int CNT_W   = 13;
  localparam int SUM_W   = 28;
  localparam int SMP_W   = 16;
  localparam int TNUM_W  = 32;
  localparam int TIME_W  = 64;
  localparam int REM_W   = CNT_W - 1;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 13;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 128;
  localparam int OUT_USED_W  = SMP_W + IDX_W + TNUM_W + TIME_W;

  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = SUM_W / DIV_BITS;

  localparam logic [CNT_W-1:0] LEN_MAX     = CNT_W'(MAX_TRACE_LEN);
  localparam logic [CNT_W-1:0] DEPTH_MAX   = CNT_W'(MAX_STACK);
  localparam logic [CNT_W-1:0] RESET_SPT   = CNT_W'(1024);
  localparam logic [CNT_W-1:0] RESET_DEPTH = CNT_W'(4);

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES_PER_TRACE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STACK_DEPTH       = 1'b1;

  localparam logic KIND_TIMESTAMP = 1'b0;
  localparam logic KIND_AVERAGE   = 1'b1;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } rts_state_t;

  typedef struct packed {
    logic                    add;
    logic                    res;
    logic                    kind;
    logic                    zero;
    logic [IDX_W-1:0]        idx;
    logic signed [SMP_W-1:0] smp;
    logic [TNUM_W-1:0]       tnum;
    logic [TIME_W-1:0]       ts;
    logic                    last;
  } acc_stage_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic              neg;
    logic              last;
    logic [IDX_W-1:0]  idx;
    logic [TNUM_W-1:0] tnum;
    logic [TIME_W-1:0] ts;
    logic [SUM_W-1:0]  quo;
    logic [REM_W-1:0]  rem;
  } div_stage_t;

  // restoring division, DIV_BITS quotient bits per call
  function automatic div_stage_t div_step(input div_stage_t s, input logic [CNT_W-1:0] dvs);
    div_stage_t       o;
    logic [CNT_W-1:0] r;
    logic             ge;
    o = s;
    for (int b = 0; b < DIV_BITS; b++) begin
      r  = {o.rem, o.quo[SUM_W-1]};
      ge = (r >= dvs);
      if (ge) begin
        r = r - dvs;
      end
      o.quo = {o.quo[SUM_W-2:0], ge};
      o.rem = r[REM_W-1:0];
    end
    return o;
  endfunction

endpackage

>>> rtl/rts_ram.sv
// ---------------------------------------------------------------------------
// rts_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module rts_ram #(
  parameter int WIDTH = 28,
  parameter int DEPTH = 4096,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/radar_trace_stacker_top.sv
// ---------------------------------------------------------------------------
// radar_trace_stacker_top
// Coherent trace stacking: per-index sums in RAM, pipelined average divider.
//
// Input stream s_*: one receiver sample per word, s_tlast marks the end of a
// buffer, s_tuser flags a dropped buffer. Output stream m_*: mid-stack
// timestamps (m_tuser = 0) and averaged trace samples (m_tuser = 1), m_tlast
// on the final averaged sample of a trace. Config writes via cfg_we while idle.
// Throughput: one word per cycle while the pipe is not stalled or clearing;
// the sum RAM is read at accept and written back from the s1 stage, with a
// bypass for back-to-back hits on one index. Pipeline: RAM read, then a
// 14-stage divider at 2 quotient bits per stage, then output register.
// Reset: rst clears control state and starts a clearing pass over all 4096
// sum RAM entries, s_tready low meanwhile. A finished stack whose buffer
// stopped short of the indices written since the last clear clears the rest
// with s_tready low: each index from the buffer position up to the highest
// index written, the sweep pausing while the final word's sum is written back.
// Stall: while m_tvalid is high and m_tready low the whole pipe holds and
// s_tready is low.
// ---------------------------------------------------------------------------
`include "radar_trace_stacker_top_assert.svh"

module radar_trace_stacker_top import rts_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample[15:0], buffer_time[79:16]
  input  logic                   s_tuser,   // buffer_dropped
  input  logic                   s_tlast,   // end_of_buffer
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // average, sample_index, trace_number,
                                            // timestamp, zero pad
  output logic                   m_tuser,   // kind
  output logic                   m_tlast,   // last
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  // configuration
  logic [CNT_W-1:0] spt_reg;
  logic [CNT_W-1:0] depth_reg;
  logic [CNT_W-1:0] len_eff;
  logic [CNT_W-1:0] depth_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      spt_reg   <= RESET_SPT;
      depth_reg <= RESET_DEPTH;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLES_PER_TRACE: spt_reg   <= cfg_data;
        REG_STACK_DEPTH:       depth_reg <= cfg_data;
      endcase
    end
  end

  assign len_eff   = (spt_reg == '0) ? CNT_W'(1) :
                     (spt_reg > LEN_MAX) ? LEN_MAX : spt_reg;
  assign depth_eff = (depth_reg == '0) ? CNT_W'(1) :
                     (depth_reg > DEPTH_MAX) ? DEPTH_MAX : depth_reg;

  // input side
  logic                    adv;
  logic                    acc;
  logic signed [SMP_W-1:0] in_smp;
  logic [TIME_W-1:0]       in_time;
  logic                    in_eob;
  logic                    in_drop;

  assign adv     = !m_tvalid || m_tready;
  assign acc     = s_tvalid && s_tready;
  assign in_smp  = s_tdata[SMP_W-1:0];
  assign in_time = s_tdata[SMP_W +: TIME_W];
  assign in_eob  = s_tlast;
  assign in_drop = s_tuser;

  // stacking control
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  stacked;
  logic [TNUM_W-1:0] done_cnt;
  logic [CNT_W-1:0]  dirty_top;

  logic [CNT_W:0]    stacked_inc;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  pos_after;
  logic              completing;
  logic              add_ok;
  logic              emit_avg;
  logic              ts_emit;
  logic              finish;
  logic              sweep_needed;

  assign stacked_inc  = {1'b0, stacked} + (CNT_W+1)'(1);
  assign completing   = stacked_inc >= {1'b0, depth_eff};
  assign add_ok       = !in_drop && (pos < len_eff);
  assign pos_inc      = pos + CNT_W'(1);
  assign pos_after    = add_ok ? pos_inc : pos;
  assign emit_avg     = add_ok && completing;
  assign ts_emit      = in_eob && !in_drop && !completing &&
                        (stacked_inc[CNT_W-1:0] == (depth_eff >> 1));
  assign finish       = in_eob && !in_drop && completing;
  assign sweep_needed = finish && (pos_after < dirty_top);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      stacked   <= '0;
      done_cnt  <= '0;
      dirty_top <= '0;
    end else if (acc) begin
      pos <= in_eob ? '0 : pos_after;
      if (in_eob && !in_drop) begin
        if (completing) begin
          stacked   <= '0;
          done_cnt  <= done_cnt + TNUM_W'(1);
          dirty_top <= '0;
        end else begin
          stacked <= stacked_inc[CNT_W-1:0];
        end
      end
      if (add_ok && !completing && (pos_inc > dirty_top)) begin
        dirty_top <= pos_inc;
      end
    end
  end

  // read-modify-write stage
  acc_stage_t              s1;
  logic                    s1_we;
  logic                    fwd_valid;
  logic [IDX_W-1:0]        fwd_addr;
  logic [SUM_W-1:0]        fwd_data;
  logic [SUM_W-1:0]        ram_rdata;
  logic signed [SUM_W-1:0] base;
  logic signed [SUM_W-1:0] sum;
  logic [SUM_W-1:0]        sum_mag;
  logic [SUM_W-1:0]        wr_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (adv) begin
      s1.add  <= acc && add_ok;
      s1.res  <= acc && (emit_avg || ts_emit);
      s1.kind <= emit_avg ? KIND_AVERAGE : KIND_TIMESTAMP;
      s1.zero <= completing;
      s1.idx  <= pos[IDX_W-1:0];
      s1.smp  <= in_smp;
      s1.tnum <= done_cnt + TNUM_W'(1);
      s1.ts   <= emit_avg ? '0 : in_time;
      s1.last <= emit_avg && (in_eob || (pos_inc == len_eff));
    end
  end

  assign s1_we   = s1.add && adv;
  assign base    = (fwd_valid && (fwd_addr == s1.idx)) ? signed'(fwd_data)
                                                       : signed'(ram_rdata);
  assign sum     = base + SUM_W'(s1.smp);
  assign sum_mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign wr_sum  = s1.zero ? '0 : SUM_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else if (adv) begin
      fwd_valid <= s1_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr <= s1.idx;
      fwd_data <= wr_sum;
    end
  end

  // clearing sweep
  rts_state_t       state;
  rts_state_t       state_next;
  logic             sweep_we;
  logic [CNT_W-1:0] sweep_addr;
  logic [CNT_W-1:0] sweep_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sweep_we   = 1'b0;
    s_tready   = 1'b0;
    unique case (state)
      ST_RUN: begin
        s_tready = adv;
        if (s_tvalid && adv && sweep_needed) begin
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        sweep_we = !s1_we;
        if (sweep_we && ((sweep_addr + CNT_W'(1)) == sweep_end)) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
      sweep_end  <= LEN_MAX;
    end else if (acc && sweep_needed) begin
      sweep_addr <= pos_after;
      sweep_end  <= dirty_top;
    end else if (sweep_we) begin
      sweep_addr <= sweep_addr + CNT_W'(1);
    end
  end

  rts_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_TRACE_LEN)
  ) u_sums (
    .clk   (clk),
    .we    (s1_we || sweep_we),
    .waddr (s1_we ? s1.idx : sweep_addr[IDX_W-1:0]),
    .wdata (s1_we ? wr_sum : '0),
    .re    (acc),
    .raddr (pos[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // divider pipeline
  div_stage_t div_in;
  div_stage_t div_q [DIV_STAGES];
  div_stage_t div_fin;

  always_comb begin
    div_in       = '0;
    div_in.valid = s1.res;
    div_in.kind  = s1.kind;
    div_in.neg   = s1.kind && sum[SUM_W-1];
    div_in.last  = s1.last;
    div_in.idx   = s1.kind ? s1.idx : '0;
    div_in.tnum  = s1.tnum;
    div_in.ts    = s1.ts;
    div_in.quo   = s1.kind ? sum_mag : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        div_q[k].valid <= 1'b0;
      end
    end else if (adv) begin
      div_q[0] <= div_in;
      for (int k = 1; k < DIV_STAGES; k++) begin
        div_q[k] <= div_step(div_q[k-1], depth_eff);
      end
    end
  end

  assign div_fin = div_step(div_q[DIV_STAGES-1], depth_eff);

  // saturate and output register
  logic [SMP_W-1:0] avg_sat;

  always_comb begin
    if (div_fin.neg) begin
      avg_sat = (div_fin.quo > SUM_W'(32768)) ? 16'h8000 : SMP_W'(-div_fin.quo);
    end else begin
      avg_sat = (div_fin.quo > SUM_W'(32767)) ? 16'h7fff : div_fin.quo[SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= div_fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {(OUT_TDATA_W-OUT_USED_W)'(0), div_fin.ts, div_fin.tnum,
                  div_fin.idx, avg_sat};
      m_tuser <= div_fin.kind;
      m_tlast <= div_fin.last;
    end
  end

  // checks
  `RTS_ASSERT_NOW(a_one_writer, s1_we, !sweep_we)
  `RTS_ASSERT_NOW(a_sweep_range, state == ST_CLEAR, sweep_addr < sweep_end)
  `RTS_ASSERT_NOW(a_pos_range, 1'b1, pos <= LEN_MAX)
  `RTS_ASSERT_NEXT(a_finish_resets, acc && finish, (stacked == '0) && (dirty_top == '0))

endmodule
